// File: src/postfix_expression_evaluator_defines.svh
// ----------------------------------------------------------------------------
// Postfix evaluator assertion macros
// Shared concurrent-assertion shorthands for the evaluator checker.
// ----------------------------------------------------------------------------
`ifndef POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PEE_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pee: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define PEE_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pee: next-cycle check failed");

// Invariant that holds at every edge out of reset.
`define PEE_ASSERT_ALWAYS(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("pee: invariant failed");

`endif

// File: src/pee_pkg.sv
// ----------------------------------------------------------------------------
// pee_pkg
// Types and constants shared by the postfix evaluator files.
// ----------------------------------------------------------------------------
`default_nettype none

package pee_pkg;

   localparam int DATA_W              = 32;
   localparam int SYM_W               = 8;
   localparam int STACK_DEPTH_DEFAULT = 16;

   // ASCII codes
   localparam logic [SYM_W-1:0] SYM_ZERO  = 8'h30;
   localparam logic [SYM_W-1:0] SYM_NINE  = 8'h39;
   localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
   localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
   localparam logic [SYM_W-1:0] SYM_STAR  = 8'h2A;
   localparam logic [SYM_W-1:0] SYM_SLASH = 8'h2F;

   // value returned by a pop from an empty stack (-999)
   localparam logic [DATA_W-1:0] ERR_VALUE = 32'hFFFF_FC19;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_POP2,
      S_POP2_WAIT,
      S_POP1,
      S_POP1_WAIT,
      S_ALU,
      S_DIV,
      S_PUSH,
      S_FIN,
      S_FIN_WAIT,
      S_EMIT
   } state_type;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV
   } op_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] quotient;
   } div_res_type;

endpackage

`default_nettype wire

// File: src/pee_if.sv
// ----------------------------------------------------------------------------
// pee_req_if / pee_rsp_if
// Valid/ready channels for symbol items in and result items out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pee_req_if import pee_pkg::*;;
   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] symbol;
   logic             has_symbol;
   logic             last;

   modport source (output valid, output symbol, output has_symbol, output last,
                   input ready);
   modport sink   (input valid, input symbol, input has_symbol, input last,
                   output ready);
endinterface

interface pee_rsp_if import pee_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] value;
   logic                     underflow;
   logic                     divide_by_zero;

   modport source (output valid, output value, output underflow,
                   output divide_by_zero, input ready);
   modport sink   (input valid, input value, input underflow,
                   input divide_by_zero, output ready);
endinterface

`default_nettype wire

// File: src/pee_ram.sv
// ----------------------------------------------------------------------------
// pee_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pee_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: src/pee_divider.sv
// ----------------------------------------------------------------------------
// pee_divider
// Iterative signed divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module pee_divider import pee_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_cmd_type cmd,
   output div_res_type      res
);

   localparam int CNT_W = $clog2(DATA_W);

   logic              busy_ff, busy_in;
   logic              fin_ff, fin_in;
   logic              done_ff, done_in;
   logic              neg_ff, neg_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic [DATA_W-1:0] q_out_ff, q_out_in;

   logic [DATA_W-1:0] mag_a, mag_b;
   logic [DATA_W:0]   shifted, diff;
   logic              take;

   assign mag_a   = cmd.dividend[DATA_W-1] ? (DATA_W'(0) - cmd.dividend) : cmd.dividend;
   assign mag_b   = cmd.divisor[DATA_W-1]  ? (DATA_W'(0) - cmd.divisor)  : cmd.divisor;
   assign shifted = {rem_ff, quo_ff[DATA_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign take    = ~diff[DATA_W];

   always_comb begin
      busy_in  = busy_ff;
      fin_in   = 1'b0;
      done_in  = fin_ff;
      neg_in   = neg_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      q_out_in = q_out_ff;
      if (cmd.start && !busy_ff) begin
         busy_in  = 1'b1;
         neg_in   = cmd.dividend[DATA_W-1] ^ cmd.divisor[DATA_W-1];
         count_in = CNT_W'(DATA_W - 1);
         rem_in   = '0;
         quo_in   = mag_a;
         dvs_in   = mag_b;
      end else if (busy_ff) begin
         rem_in   = take ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
         quo_in   = {quo_ff[DATA_W-2:0], take};
         count_in = count_ff - CNT_W'(1);
         if (count_ff == '0) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
      if (fin_ff) begin
         q_out_in = neg_ff ? (DATA_W'(0) - quo_ff) : quo_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff   <= neg_in;
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dvs_ff   <= dvs_in;
      q_out_ff <= q_out_in;
   end

   assign res.done     = done_ff;
   assign res.quotient = q_out_ff;

endmodule

`default_nettype wire

// File: src/postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Reverse Polish evaluator over a bounded operand stack held in RAM.
// ----------------------------------------------------------------------------
// One item carries one ASCII character. Digits push 0..9; + - * / pop the
// second then the first operand and push the result (32-bit wrap, division
// truncates toward zero, a zero divisor gives 0 and raises divide_by_zero).
// A push onto a full stack is dropped; a pop from an empty stack gives -999
// and raises underflow. The item with last set is evaluated, then the top is
// popped and emitted as one result item, and the stack and flags clear.
// Timing: one item at a time. A digit or a skipped character is taken in
// and executed; + - * add two stack pops through the RAM's registered read,
// the ALU step and the write-back (a pop that finds the stack empty skips
// its read wait state); / also runs the 32-step divider, skipped when the
// divisor is zero. A last item adds the final pop and the output register
// load. The output register lets the next item enter while a result waits;
// a second last item waits there until the first is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module postfix_expression_evaluator import pee_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   pee_req_if.sink    req_ch,
   pee_rsp_if.source  rsp_ch
);

   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(STACK_DEPTH);

   // control state
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  top_ff, top_in;        // entries held
   logic              uf_ff, uf_in;          // underflow seen in this expression
   logic              dz_ff, dz_in;          // zero divisor seen
   logic              rsp_valid_ff, rsp_valid_in;

   // captured item and operands
   logic [SYM_W-1:0]  sym_ff, sym_in;
   logic              has_ff, has_in;
   logic              last_ff, last_in;
   op_type            op_ff, op_in;
   logic [DATA_W-1:0] opnd_a_ff, opnd_a_in; // first operand
   logic [DATA_W-1:0] opnd_b_ff, opnd_b_in; // second operand
   logic [DATA_W-1:0] result_ff, result_in;
   logic [DATA_W-1:0] fin_ff, fin_in;       // final popped value
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_uf_ff, rsp_uf_in;
   logic              rsp_dz_ff, rsp_dz_in;

   // RAM port
   logic              ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [DATA_W-1:0] ram_wr_data, ram_rd_data;

   div_cmd_type       div_cmd;
   div_res_type       div_res;

   logic              req_accept;
   logic              is_digit, is_op, empty, full, slot_free;
   logic [CNT_W-1:0]  top_dec;
   op_type            op_dec;

   assign req_accept = req_ch.valid && req_ch.ready;
   assign is_digit   = (sym_ff >= SYM_ZERO) && (sym_ff <= SYM_NINE);
   assign is_op      = (sym_ff == SYM_PLUS) || (sym_ff == SYM_MINUS) ||
                       (sym_ff == SYM_STAR) || (sym_ff == SYM_SLASH);
   assign empty      = (top_ff == '0);
   assign full       = (top_ff == FULL_COUNT);
   assign top_dec    = top_ff - CNT_W'(1);
   // result register free now or being taken this cycle
   assign slot_free  = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      unique case (sym_ff)
         SYM_PLUS:  op_dec = OP_ADD;
         SYM_MINUS: op_dec = OP_SUB;
         SYM_STAR:  op_dec = OP_MUL;
         default:   op_dec = OP_DIV;
      endcase
   end

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:      if (req_accept) state_in = S_EXEC;
         S_EXEC: begin
            priority if (has_ff && is_op) state_in = S_POP2;
            else if (last_ff)             state_in = S_FIN;
            else                          state_in = S_IDLE;
         end
         S_POP2:      state_in = empty ? S_POP1 : S_POP2_WAIT;
         S_POP2_WAIT: state_in = S_POP1;
         S_POP1:      state_in = empty ? S_ALU : S_POP1_WAIT;
         S_POP1_WAIT: state_in = S_ALU;
         S_ALU: begin
            if ((op_ff == OP_DIV) && (opnd_b_ff != '0)) state_in = S_DIV;
            else                                        state_in = S_PUSH;
         end
         S_DIV:       if (div_res.done) state_in = S_PUSH;
         S_PUSH:      state_in = last_ff ? S_FIN : S_IDLE;
         S_FIN:       state_in = empty ? S_EMIT : S_FIN_WAIT;
         S_FIN_WAIT:  state_in = S_EMIT;
         S_EMIT:      if (slot_free) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- datapath
   // Accesses never overlap: each pop reads only after the previous write has
   // landed, so no forwarding path is needed.
   always_comb begin
      req_ch.ready     = 1'b0;
      ram_wr_en        = 1'b0;
      ram_wr_addr      = top_ff[ADDR_W-1:0];
      ram_wr_data      = result_ff;
      ram_rd_en        = 1'b0;
      ram_rd_addr      = top_dec[ADDR_W-1:0];
      div_cmd.start    = 1'b0;
      div_cmd.dividend = opnd_a_ff;
      div_cmd.divisor  = opnd_b_ff;

      top_in       = top_ff;
      uf_in        = uf_ff;
      dz_in        = dz_ff;
      sym_in       = sym_ff;
      has_in       = has_ff;
      last_in      = last_ff;
      op_in        = op_ff;
      opnd_a_in    = opnd_a_ff;
      opnd_b_in    = opnd_b_ff;
      result_in    = result_ff;
      fin_in       = fin_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in = rsp_value_ff;
      rsp_uf_in    = rsp_uf_ff;
      rsp_dz_in    = rsp_dz_ff;

      unique case (state_ff)
         S_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_accept) begin
               sym_in  = req_ch.symbol;
               has_in  = req_ch.has_symbol;
               last_in = req_ch.last;
            end
         end
         S_EXEC: begin
            if (has_ff && is_digit && !full) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = DATA_W'(sym_ff - SYM_ZERO);
               top_in      = top_ff + CNT_W'(1);
            end
            op_in = op_dec;
         end
         S_POP2: begin
            if (empty) begin
               uf_in     = 1'b1;
               opnd_b_in = ERR_VALUE;
            end else begin
               ram_rd_en = 1'b1;
               top_in    = top_dec;
            end
         end
         S_POP2_WAIT: opnd_b_in = ram_rd_data;
         S_POP1: begin
            if (empty) begin
               uf_in     = 1'b1;
               opnd_a_in = ERR_VALUE;
            end else begin
               ram_rd_en = 1'b1;
               top_in    = top_dec;
            end
         end
         S_POP1_WAIT: opnd_a_in = ram_rd_data;
         S_ALU: begin
            unique case (op_ff)
               OP_ADD: result_in = opnd_a_ff + opnd_b_ff;
               OP_SUB: result_in = opnd_a_ff - opnd_b_ff;
               OP_MUL: result_in = DATA_W'(opnd_a_ff * opnd_b_ff);
               OP_DIV: begin
                  if (opnd_b_ff == '0) begin
                     result_in = '0;
                     dz_in     = 1'b1;
                  end else begin
                     div_cmd.start = 1'b1;
                  end
               end
               default: result_in = result_ff;
            endcase
         end
         S_DIV: if (div_res.done) result_in = div_res.quotient;
         S_PUSH: begin
            if (!full) begin
               ram_wr_en = 1'b1;
               top_in    = top_ff + CNT_W'(1);
            end
         end
         S_FIN: begin
            if (empty) begin
               uf_in  = 1'b1;
               fin_in = ERR_VALUE;
            end else begin
               ram_rd_en = 1'b1;
            end
         end
         S_FIN_WAIT: fin_in = ram_rd_data;
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = fin_ff;
               rsp_uf_in    = uf_ff;
               rsp_dz_in    = dz_ff;
               top_in       = '0;
               uf_in        = 1'b0;
               dz_in        = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         top_ff       <= '0;
         uf_ff        <= 1'b0;
         dz_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         uf_ff        <= uf_in;
         dz_ff        <= dz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff       <= sym_in;
      has_ff       <= has_in;
      last_ff      <= last_in;
      op_ff        <= op_in;
      opnd_a_ff    <= opnd_a_in;
      opnd_b_ff    <= opnd_b_in;
      result_ff    <= result_in;
      fin_ff       <= fin_in;
      rsp_value_ff <= rsp_value_in;
      rsp_uf_ff    <= rsp_uf_in;
      rsp_dz_ff    <= rsp_dz_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.value          = rsp_value_ff;
   assign rsp_ch.underflow      = rsp_uf_ff;
   assign rsp_ch.divide_by_zero = rsp_dz_ff;

   // operand stack
   pee_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   pee_divider u_divider (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

endmodule

`default_nettype wire

// File: src/pee_checker.sv
// ----------------------------------------------------------------------------
// pee_checker
// Port-level checks on the postfix evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "postfix_expression_evaluator_defines.svh"

module pee_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic req_last,
   input wire logic rsp_valid,
   input wire logic rsp_ready
);

   // last items taken in but not yet delivered
   logic [1:0] pending_ff, pending_in;
   logic       last_acc, rsp_acc;

   assign last_acc = req_valid && req_ready && req_last;
   assign rsp_acc  = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff + {1'b0, last_acc} - {1'b0, rsp_acc};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `PEE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `PEE_ASSERT_IMP(a_rsp_has_cause, clock, reset, rsp_valid, pending_ff != 2'd0)
   `PEE_ASSERT_ALWAYS(a_pending_bound, clock, reset, pending_ff != 2'd3)
   `PEE_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)

endmodule

bind postfix_expression_evaluator pee_checker u_pee_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .req_last  (req_ch.last),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready)
);

`default_nettype wire
